[sv/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Stand-alone header, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[sv/fds_pkg.sv]
// Package of the frame difference statistics block: field widths and shared types.
// No dependencies.
`default_nettype none

package fds_pkg;

   localparam int PIX_W  = 8;
   localparam int SAD_W  = 34;
   localparam int CH_W   = 32;
   localparam int CNT_W  = 25;
   localparam int DPP_W  = 18;
   localparam int MEAN_W = 16;

   // One pixel pair as taken from the request channel.
   typedef struct packed {
      logic [PIX_W-1:0] cur_ch1;
      logic [PIX_W-1:0] cur_ch2;
      logic [PIX_W-1:0] cur_ch3;
      logic [PIX_W-1:0] prev_ch1;
      logic [PIX_W-1:0] prev_ch2;
      logic [PIX_W-1:0] prev_ch3;
      logic             last_pixel;
   } pix_type;

   // Control from the sequencer to the accumulators.
   typedef struct packed {
      logic add;
      logic clear;
      logic avg_en;
   } acc_ctl_type;

   // Running frame sums.
   typedef struct packed {
      logic [SAD_W-1:0] sad;
      logic [CH_W-1:0]  ch1;
      logic [CH_W-1:0]  ch2;
      logic [CH_W-1:0]  ch3;
      logic [CNT_W-1:0] cnt;
   } acc_sums_type;

   // Which quotient the shared divider is working on.
   typedef enum logic [1:0] {
      SEL_SAD = 2'd0,
      SEL_CH1 = 2'd1,
      SEL_CH2 = 2'd2,
      SEL_CH3 = 2'd3
   } sel_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_EMIT = 4'b1000
   } st_type;

endpackage

`default_nettype wire

[sv/fds_if.sv]
// Handshake interfaces of the frame difference statistics block.
// Depends on fds_pkg for the field widths.
`default_nettype none

// Pixel pair request channel.
interface fds_req_if import fds_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] cur_ch1;
   logic [PIX_W-1:0] cur_ch2;
   logic [PIX_W-1:0] cur_ch3;
   logic [PIX_W-1:0] prev_ch1;
   logic [PIX_W-1:0] prev_ch2;
   logic [PIX_W-1:0] prev_ch3;
   logic             last_pixel;

   modport source (output valid, cur_ch1, cur_ch2, cur_ch3, prev_ch1, prev_ch2, prev_ch3,
                   last_pixel, input ready);
   modport sink (input valid, cur_ch1, cur_ch2, cur_ch3, prev_ch1, prev_ch2, prev_ch3,
                 last_pixel, output ready);
endinterface

// Frame statistics response channel.
interface fds_rsp_if import fds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SAD_W-1:0]  sad_total;
   logic [CNT_W-1:0]  pixel_total;
   logic [DPP_W-1:0]  diff_per_pixel;
   logic [MEAN_W-1:0] mean_ch1;
   logic [MEAN_W-1:0] mean_ch2;
   logic [MEAN_W-1:0] mean_ch3;

   modport source (output valid, sad_total, pixel_total, diff_per_pixel, mean_ch1, mean_ch2,
                   mean_ch3, input ready);
   modport sink (input valid, sad_total, pixel_total, diff_per_pixel, mean_ch1, mean_ch2,
                 mean_ch3, output ready);
endinterface

// Register write channel for the averages enable.
interface fds_csr_if ();
   logic valid;
   logic ready;
   logic averages_enable;

   modport source (output valid, averages_enable, input ready);
   modport sink (input valid, averages_enable, output ready);
endinterface

`default_nettype wire

[sv/fds_accum.sv]
// Frame accumulators: absolute-difference sum, channel sums and pixel count.
// Depends on fds_pkg.
`default_nettype none

module fds_accum import fds_pkg::*; #(
   parameter int MAX_FRAME_PIXELS = 16777216
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire acc_ctl_type  ctl,
   input  wire pix_type      pix,
   output      acc_sums_type sums,
   output      logic         close
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_PIXELS);

   logic [SAD_W-1:0] sad_ff, sad_in;
   logic [CH_W-1:0]  ch1_ff, ch1_in;
   logic [CH_W-1:0]  ch2_ff, ch2_in;
   logic [CH_W-1:0]  ch3_ff, ch3_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_inc;
   logic [PIX_W-1:0] d1, d2, d3;
   logic [PIX_W+1:0] dsum;

   // Per-channel absolute differences and their sum.
   always_comb begin
      d1   = (pix.cur_ch1 >= pix.prev_ch1) ? pix.cur_ch1 - pix.prev_ch1
                                           : pix.prev_ch1 - pix.cur_ch1;
      d2   = (pix.cur_ch2 >= pix.prev_ch2) ? pix.cur_ch2 - pix.prev_ch2
                                           : pix.prev_ch2 - pix.cur_ch2;
      d3   = (pix.cur_ch3 >= pix.prev_ch3) ? pix.cur_ch3 - pix.prev_ch3
                                           : pix.prev_ch3 - pix.cur_ch3;
      dsum = (PIX_W+2)'(d1) + (PIX_W+2)'(d2) + (PIX_W+2)'(d3);
   end

   // The frame closes on the marked pixel or when the count reaches its limit.
   assign cnt_inc = cnt_ff + CNT_W'(1);
   assign close   = pix.last_pixel || (cnt_inc >= MAX_CNT);

   // Next values of the accumulators.
   always_comb begin
      sad_in = sad_ff;
      ch1_in = ch1_ff;
      ch2_in = ch2_ff;
      ch3_in = ch3_ff;
      cnt_in = cnt_ff;
      priority if (ctl.clear) begin
         sad_in = '0;
         ch1_in = '0;
         ch2_in = '0;
         ch3_in = '0;
         cnt_in = '0;
      end else if (ctl.add) begin
         sad_in = sad_ff + SAD_W'(dsum);
         cnt_in = cnt_inc;
         if (ctl.avg_en) begin
            ch1_in = ch1_ff + CH_W'(pix.cur_ch1);
            ch2_in = ch2_ff + CH_W'(pix.cur_ch2);
            ch3_in = ch3_ff + CH_W'(pix.cur_ch3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sad_ff <= '0;
         ch1_ff <= '0;
         ch2_ff <= '0;
         ch3_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sad_ff <= sad_in;
         ch1_ff <= ch1_in;
         ch2_ff <= ch2_in;
         ch3_ff <= ch3_in;
         cnt_ff <= cnt_in;
      end
   end

   assign sums = '{sad: sad_ff, ch1: ch1_ff, ch2: ch2_ff, ch3: ch3_ff, cnt: cnt_ff};

endmodule

`default_nettype wire

[sv/fds_divider.sv]
// Shared restoring divider, one quotient bit per cycle; keeps the low quotient bits.
// Depends on fds_pkg.
`default_nettype none

module fds_divider import fds_pkg::*; #(
   parameter int NUM_W = 42
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [CNT_W-1:0] denom,
   output      logic             done,
   output      logic [DPP_W-1:0] quot
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DPP_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // One trial subtraction of the shifted remainder.
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      priority if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = '0;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[DPP_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

[sv/frame_difference_sad_stats.sv]
// Top level of the frame difference statistics block: sequencer, output register.
// Depends on fds_pkg, fds_if, fds_accum and fds_divider.
//
//   channel | direction | handshake          | payload
//   req_if  | in        | valid/ready        | cur_ch1..3, prev_ch1..3, last_pixel
//   rsp_if  | out       | valid/ready        | sad_total, pixel_total, diff_per_pixel,
//           |           |                    | mean_ch1..3
//   csr_if  | in        | valid/ready (rdy=1)| averages_enable
//
// A pixel that does not close the frame is accepted while the block is idle; requests may
// arrive back to back. A closing pixel occupies the block while its k quotients are formed,
// k = 4 with averages enabled and 1 otherwise; the single shared divider produces one
// quotient bit per cycle for each of the k quotients, one quotient after another.
// Reset is synchronous and active high; it clears the sums and sets the enable.
// A response left waiting on rsp_if stalls requests only once the next frame closes:
// the block then stays in the emit state until that response is taken.
`default_nettype none

module frame_difference_sad_stats import fds_pkg::*; #(
   parameter int MAX_FRAME_PIXELS = 16777216,
   parameter int FRACTION_BITS    = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   fds_req_if.sink   req_if,
   fds_rsp_if.source rsp_if,
   fds_csr_if.sink   csr_if
);

   localparam int NUM_W = SAD_W + FRACTION_BITS;

   st_type            state_ff, state_in;
   sel_type           sel_ff, sel_in;
   logic              en_ff, en_in;
   logic [DPP_W-1:0]  dpp_ff, dpp_in;
   logic [MEAN_W-1:0] m1_ff, m1_in;
   logic [MEAN_W-1:0] m2_ff, m2_in;
   logic [MEAN_W-1:0] m3_ff, m3_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SAD_W-1:0]  rsp_sad_ff, rsp_sad_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [DPP_W-1:0]  rsp_dpp_ff, rsp_dpp_in;
   logic [MEAN_W-1:0] rsp_m1_ff, rsp_m1_in;
   logic [MEAN_W-1:0] rsp_m2_ff, rsp_m2_in;
   logic [MEAN_W-1:0] rsp_m3_ff, rsp_m3_in;

   logic              req_accept;
   logic              emit_fire;
   logic              div_start;
   logic              div_done;
   logic [DPP_W-1:0]  div_quot;
   logic [NUM_W-1:0]  div_numer;
   logic              close;
   pix_type           pix;
   acc_ctl_type       acc_ctl;
   acc_sums_type      sums;

   // Request handshake and register port.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && req_if.ready;
   assign en_in        = (csr_if.valid) ? csr_if.averages_enable : en_ff;

   // The response slot is free when empty or being drained in this cycle.
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   assign pix = '{cur_ch1: req_if.cur_ch1, cur_ch2: req_if.cur_ch2,
                  cur_ch3: req_if.cur_ch3, prev_ch1: req_if.prev_ch1,
                  prev_ch2: req_if.prev_ch2, prev_ch3: req_if.prev_ch3,
                  last_pixel: req_if.last_pixel};
   assign acc_ctl = '{add: req_accept, clear: emit_fire, avg_en: en_ff};

   fds_accum #(
      .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
   ) u_accum (
      .clock (clock),
      .reset (reset),
      .ctl   (acc_ctl),
      .pix   (pix),
      .sums  (sums),
      .close (close)
   );

   // Dividend for the quotient currently selected.
   always_comb begin
      unique case (sel_ff)
         SEL_SAD: div_numer = NUM_W'(sums.sad) << FRACTION_BITS;
         SEL_CH1: div_numer = NUM_W'(sums.ch1) << FRACTION_BITS;
         SEL_CH2: div_numer = NUM_W'(sums.ch2) << FRACTION_BITS;
         SEL_CH3: div_numer = NUM_W'(sums.ch3) << FRACTION_BITS;
         default: div_numer = '0;
      endcase
   end

   assign div_start = (state_ff == ST_LOAD);

   fds_divider #(
      .NUM_W(NUM_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (sums.cnt),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Sequencer: accumulate, then run the quotients one after another, then emit the response.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      dpp_in   = dpp_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      m3_in    = m3_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && close) begin
               state_in = ST_LOAD;
               sel_in   = SEL_SAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               unique case (sel_ff)
                  SEL_SAD: dpp_in = div_quot;
                  SEL_CH1: m1_in  = div_quot[MEAN_W-1:0];
                  SEL_CH2: m2_in  = div_quot[MEAN_W-1:0];
                  SEL_CH3: m3_in  = div_quot[MEAN_W-1:0];
                  default: dpp_in = div_quot;
               endcase
               priority if ((sel_ff == SEL_SAD && !en_ff) || sel_ff == SEL_CH3) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_LOAD;
                  unique case (sel_ff)
                     SEL_SAD: sel_in = SEL_CH1;
                     SEL_CH1: sel_in = SEL_CH2;
                     SEL_CH2: sel_in = SEL_CH3;
                     default: sel_in = SEL_SAD;
                  endcase
               end
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sad_in   = rsp_sad_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_dpp_in   = rsp_dpp_ff;
      rsp_m1_in    = rsp_m1_ff;
      rsp_m2_in    = rsp_m2_ff;
      rsp_m3_in    = rsp_m3_ff;
      priority if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_sad_in   = sums.sad;
         rsp_cnt_in   = sums.cnt;
         rsp_dpp_in   = dpp_ff;
         rsp_m1_in    = en_ff ? m1_ff : '0;
         rsp_m2_in    = en_ff ? m2_ff : '0;
         rsp_m3_in    = en_ff ? m3_ff : '0;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_SAD;
         en_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         en_ff        <= en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dpp_ff     <= dpp_in;
      m1_ff      <= m1_in;
      m2_ff      <= m2_in;
      m3_ff      <= m3_in;
      rsp_sad_ff <= rsp_sad_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_dpp_ff <= rsp_dpp_in;
      rsp_m1_ff  <= rsp_m1_in;
      rsp_m2_ff  <= rsp_m2_in;
      rsp_m3_ff  <= rsp_m3_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.sad_total      = rsp_sad_ff;
   assign rsp_if.pixel_total    = rsp_cnt_ff;
   assign rsp_if.diff_per_pixel = rsp_dpp_ff;
   assign rsp_if.mean_ch1       = rsp_m1_ff;
   assign rsp_if.mean_ch2       = rsp_m2_ff;
   assign rsp_if.mean_ch3       = rsp_m3_ff;

endmodule

`default_nettype wire

[sv/fds_checker.sv]
// Port-level checks of the frame difference statistics block, bound to the top level.
// Depends on fds_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fds_checker (
   input wire logic  clock,
   input wire logic  reset,
   fds_req_if.sink   req_if,
   fds_rsp_if.source rsp_if
);

   // A response that is not taken stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_if.valid && !rsp_if.ready, rsp_if.valid)

   // A pixel marked as last stalls the request side once it is taken.
   `ASSERT_NEXT(a_close_stall, clock, reset, req_if.valid && req_if.ready && req_if.last_pixel, !req_if.ready)

   // Every reported frame holds at least one pixel.
   `ASSERT_IMPLY(a_count_nonzero, clock, reset, rsp_if.valid, rsp_if.pixel_total != '0)

   // A pixel never raises the difference sum above three full-scale channels per pixel.
   `ASSERT_IMPLY(a_sad_bound, clock, reset, rsp_if.valid, rsp_if.sad_total <= 34'(rsp_if.pixel_total) * 34'd765)

endmodule

bind frame_difference_sad_stats fds_checker u_fds_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

`default_nettype wire
